// File: hw/rtl/wavhp_pkg.sv
// Package for the WAV header parser: status and error codes, parse phases,
// the structs passed between modules, and the marker and field-length tables.
// No dependencies.
package wavhp_pkg;

    // Result status codes.
    localparam logic [2:0] ST_HEADER   = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_PAYLOAD  = 3'd2;
    localparam logic [2:0] ST_TRAILING = 3'd3;
    localparam logic [2:0] ST_ERROR    = 3'd4;

    // Error codes.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_RIFF  = 3'd1;
    localparam logic [2:0] ERR_NO_WAVE  = 3'd2;
    localparam logic [2:0] ERR_NO_FMT   = 3'd3;
    localparam logic [2:0] ERR_NOT_PCM  = 3'd4;
    localparam logic [2:0] ERR_NO_DATA  = 3'd5;
    localparam logic [2:0] ERR_ZERO_DIV = 3'd6;

    // Marker words, first file byte in the low byte.
    localparam logic [31:0] MARK_RIFF = 32'h4646_4952;  // "RIFF"
    localparam logic [31:0] MARK_WAVE = 32'h4556_4157;  // "WAVE"
    localparam logic [31:0] MARK_FMT  = 32'h2074_6D66;  // "fmt "
    localparam logic [31:0] MARK_DATA = 32'h6174_6164;  // "data"
    localparam logic [31:0] MARK_PCM  = 32'h0000_0001;  // format tag 1

    // Fmt chunk length covered by the fields that are parsed.
    localparam logic [31:0] FMT_BASE_LEN = 32'd16;

    // Parse phases, one-hot.
    typedef enum logic [18:0] {
        PH_RIFF        = 19'h00001,
        PH_RIFF_SIZE   = 19'h00002,
        PH_WAVE        = 19'h00004,
        PH_FMT         = 19'h00008,
        PH_FMT_LEN     = 19'h00010,
        PH_TAG         = 19'h00020,
        PH_CHANNELS    = 19'h00040,
        PH_RATE        = 19'h00080,
        PH_BYTE_RATE   = 19'h00100,
        PH_BLOCK_ALIGN = 19'h00200,
        PH_BITS        = 19'h00400,
        PH_SKIP        = 19'h00800,
        PH_DATA_MARK   = 19'h01000,
        PH_DATA_SIZE   = 19'h02000,
        PH_PAYLOAD     = 19'h04000,
        PH_TRAILING    = 19'h08000,
        PH_DIV1        = 19'h10000,
        PH_DIV2        = 19'h20000,
        PH_REPORT      = 19'h40000
    } phase_t;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    // Response from the shared divider.
    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    // One result transaction.
    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  error_code;
        logic [7:0]  payload_byte;
        logic        last_payload;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [31:0] payload_length;
        logic [31:0] frame_count;
    } result_t;

    // Index of the last byte of the field read in a phase.
    function automatic logic [1:0] field_last(input phase_t ph);
        logic [1:0] last;
        unique case (ph)
            PH_TAG, PH_CHANNELS, PH_BLOCK_ALIGN, PH_BITS: last = 2'd1;
            default: last = 2'd3;
        endcase
        return last;
    endfunction

    // Error raised when a marker byte of this phase does not match.
    function automatic logic [2:0] marker_code(input phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_RIFF:      code = ERR_NO_RIFF;
            PH_WAVE:      code = ERR_NO_WAVE;
            PH_FMT:       code = ERR_NO_FMT;
            PH_TAG:       code = ERR_NOT_PCM;
            PH_DATA_MARK: code = ERR_NO_DATA;
            default:      code = ERR_NONE;
        endcase
        return code;
    endfunction

    // Expected byte at a position of the marker of this phase.
    function automatic logic [7:0] marker_byte(input phase_t ph, input logic [1:0] pos);
        logic [31:0] word;
        unique case (ph)
            PH_RIFF:      word = MARK_RIFF;
            PH_WAVE:      word = MARK_WAVE;
            PH_FMT:       word = MARK_FMT;
            PH_TAG:       word = MARK_PCM;
            PH_DATA_MARK: word = MARK_DATA;
            default:      word = 32'd0;
        endcase
        return word[{pos, 3'b000} +: 8];
    endfunction

    // Phase that follows a plain field.
    function automatic phase_t next_phase(input phase_t ph);
        phase_t nxt;
        unique case (ph)
            PH_RIFF:        nxt = PH_RIFF_SIZE;
            PH_RIFF_SIZE:   nxt = PH_WAVE;
            PH_WAVE:        nxt = PH_FMT;
            PH_FMT:         nxt = PH_FMT_LEN;
            PH_FMT_LEN:     nxt = PH_TAG;
            PH_TAG:         nxt = PH_CHANNELS;
            PH_CHANNELS:    nxt = PH_RATE;
            PH_RATE:        nxt = PH_BYTE_RATE;
            PH_BYTE_RATE:   nxt = PH_BLOCK_ALIGN;
            PH_BLOCK_ALIGN: nxt = PH_BITS;
            PH_DATA_MARK:   nxt = PH_DATA_SIZE;
            default:        nxt = ph;
        endcase
        return nxt;
    endfunction

endpackage

// File: hw/rtl/wavhp_divider.sv
// Shared restoring divider, 32-bit dividend by 16-bit divisor, one quotient
// bit per cycle. Depends on wavhp_pkg.
module wavhp_divider
    import wavhp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [15:0] dsr_reg;

    logic [16:0] trial;
    logic [16:0] diff;
    logic        fits;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[31]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    // Control: count 32 steps after a start and pulse done at the end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and the dividend that turns into the quotient.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= 16'd0;
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[15:0] : trial[15:0];
            dvd_reg <= {dvd_reg[30:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

// File: hw/rtl/wavhp_parser.sv
// Byte-level parse sequencer: markers, little-endian fields, fmt skip,
// payload count and the frame-count division steps. Depends on wavhp_pkg.
module wavhp_parser
    import wavhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       out_free,
    input  logic [7:0] data_byte,
    input  logic       first_of_file,
    input  div_rsp_t   div_rsp,
    output div_req_t   div_req,
    output result_t    res,
    output logic       res_load,
    output logic       busy
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] remain_reg, remain_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] frames_reg, frames_next;
    logic [2:0]  err_reg, err_next;

    phase_t      cur_phase;
    logic [1:0]  cur_pos;
    logic [31:0] cur_shift;
    logic [31:0] cur_skip;
    logic [31:0] cur_remain;
    logic [15:0] cur_chan;
    logic [15:0] cur_bits;
    logic [2:0]  cur_err;
    logic [31:0] value;
    logic [31:0] count_dec;
    logic [2:0]  code;
    logic        meta;

    // Sequencer and field assembly.
    always_comb
    begin
        // A first-of-file byte sees the cleared state.
        cur_phase  = first_of_file ? PH_RIFF : phase_reg;
        cur_pos    = first_of_file ? 2'd0 : pos_reg;
        cur_shift  = first_of_file ? 32'd0 : shift_reg;
        cur_skip   = first_of_file ? 32'd0 : skip_reg;
        cur_remain = first_of_file ? 32'd0 : remain_reg;
        cur_chan   = first_of_file ? 16'd0 : chan_reg;
        cur_bits   = first_of_file ? 16'd0 : bits_reg;
        cur_err    = first_of_file ? ERR_NONE : err_reg;

        value     = cur_shift | ({24'd0, data_byte} << {cur_pos, 3'b000});
        count_dec = 32'd0;
        code      = marker_code(cur_phase);

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        shift_next  = shift_reg;
        skip_next   = skip_reg;
        remain_next = remain_reg;
        chan_next   = chan_reg;
        rate_next   = rate_reg;
        bits_next   = bits_reg;
        size_next   = size_reg;
        frames_next = frames_reg;
        err_next    = err_reg;

        res          = '0;
        res_load     = 1'b0;
        div_req      = '0;

        if (accept)
        begin
            res_load = 1'b1;
            if (first_of_file)
            begin
                phase_next  = PH_RIFF;
                pos_next    = 2'd0;
                shift_next  = 32'd0;
                skip_next   = 32'd0;
                remain_next = 32'd0;
                chan_next   = 16'd0;
                rate_next   = 32'd0;
                bits_next   = 16'd0;
                size_next   = 32'd0;
                frames_next = 32'd0;
                err_next    = ERR_NONE;
            end

            if (cur_err != ERR_NONE)
            begin
                res.status     = ST_ERROR;
                res.error_code = cur_err;
            end
            else
            begin
                unique case (cur_phase)
                    PH_TRAILING:
                    begin
                        res.status = ST_TRAILING;
                    end
                    PH_PAYLOAD:
                    begin
                        count_dec        = cur_remain - 32'd1;
                        remain_next      = count_dec;
                        res.status       = ST_PAYLOAD;
                        res.payload_byte = data_byte;
                        if (count_dec == 32'd0)
                        begin
                            phase_next       = PH_TRAILING;
                            res.last_payload = 1'b1;
                        end
                    end
                    PH_SKIP:
                    begin
                        count_dec  = cur_skip - 32'd1;
                        skip_next  = count_dec;
                        res.status = ST_HEADER;
                        if (count_dec == 32'd0)
                        begin
                            phase_next = PH_DATA_MARK;
                            pos_next   = 2'd0;
                            shift_next = 32'd0;
                        end
                    end
                    default:
                    begin
                        res.status = ST_HEADER;
                        if ((code != ERR_NONE) && (data_byte != marker_byte(cur_phase, cur_pos)))
                        begin
                            err_next       = code;
                            res.status     = ST_ERROR;
                            res.error_code = code;
                        end
                        else if (cur_pos != field_last(cur_phase))
                        begin
                            pos_next   = cur_pos + 2'd1;
                            shift_next = value;
                        end
                        else
                        begin
                            // Field complete.
                            pos_next   = 2'd0;
                            shift_next = 32'd0;
                            phase_next = next_phase(cur_phase);
                            unique case (cur_phase)
                                PH_FMT_LEN:
                                begin
                                    skip_next = (value >= FMT_BASE_LEN) ?
                                                (value - FMT_BASE_LEN) : 32'd0;
                                end
                                PH_CHANNELS:
                                begin
                                    chan_next = value[15:0];
                                end
                                PH_RATE:
                                begin
                                    rate_next = value;
                                end
                                PH_BITS:
                                begin
                                    bits_next  = value[15:0];
                                    phase_next = (cur_skip != 32'd0) ? PH_SKIP : PH_DATA_MARK;
                                end
                                PH_DATA_SIZE:
                                begin
                                    size_next = value;
                                    if ((cur_chan == 16'd0) || (cur_bits == 16'd0))
                                    begin
                                        err_next       = ERR_ZERO_DIV;
                                        res.status     = ST_ERROR;
                                        res.error_code = ERR_ZERO_DIV;
                                    end
                                    else
                                    begin
                                        // Size over channels first; the result comes later.
                                        div_req.start    = 1'b1;
                                        div_req.dividend = value;
                                        div_req.divisor  = cur_chan;
                                        phase_next       = PH_DIV1;
                                        res_load         = 1'b0;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                endcase
            end
        end
        else
        begin
            // Frame-count steps while the input side is held off.
            unique case (phase_reg)
                PH_DIV1:
                begin
                    if (div_rsp.done)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {div_rsp.quotient[28:0], 3'b000};
                        div_req.divisor  = bits_reg;
                        phase_next       = PH_DIV2;
                    end
                end
                PH_DIV2:
                begin
                    if (div_rsp.done)
                    begin
                        frames_next = div_rsp.quotient;
                        phase_next  = PH_REPORT;
                    end
                end
                PH_REPORT:
                begin
                    if (out_free)
                    begin
                        res_load    = 1'b1;
                        res.status  = ST_COMPLETE;
                        remain_next = size_reg;
                        phase_next  = (size_reg != 32'd0) ? PH_PAYLOAD : PH_TRAILING;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Metadata goes out with header complete, payload and trailing results.
        meta = (res.status == ST_COMPLETE) || (res.status == ST_PAYLOAD) ||
               (res.status == ST_TRAILING);
        if (meta)
        begin
            res.channel_count  = chan_next;
            res.sample_rate    = rate_next;
            res.sample_bits    = bits_next;
            res.payload_length = size_next;
            res.frame_count    = frames_next;
        end
    end

    assign busy = (phase_reg == PH_DIV1) || (phase_reg == PH_DIV2) ||
                  (phase_reg == PH_REPORT);

    // Parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RIFF;
            pos_reg    <= 2'd0;
            shift_reg  <= 32'd0;
            skip_reg   <= 32'd0;
            remain_reg <= 32'd0;
            chan_reg   <= 16'd0;
            rate_reg   <= 32'd0;
            bits_reg   <= 16'd0;
            size_reg   <= 32'd0;
            frames_reg <= 32'd0;
            err_reg    <= ERR_NONE;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            shift_reg  <= shift_next;
            skip_reg   <= skip_next;
            remain_reg <= remain_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            bits_reg   <= bits_next;
            size_reg   <= size_next;
            frames_reg <= frames_next;
            err_reg    <= err_next;
        end
    end

endmodule

// File: hw/rtl/wav_header_parser.sv
// Top level of the WAV header parser: input handshake, output register and
// the wiring of the parse sequencer and the shared divider.
// Depends on wavhp_pkg, wavhp_divider and wavhp_parser.
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+---------------------------------------
//  byte    | byte_valid / byte_stall    | data_byte, first_of_file
//  result  | result_valid/result_stall  | status, error_code, payload_byte,
//          |                            | last_payload and the header metadata
//
// Each file byte gives one result in the cycle after it is taken, except the
// last data-size byte of a header with nonzero channels and bits: it gives none
// and holds the byte side off while the 32-step divider runs twice for the frame
// count. Payload bytes stream at one per cycle while the result side does not stall.
// Reset clears all parse state and empties the output register.
// A stalled result holds its register; the byte side is stalled while that
// register cannot be refilled and while the frame count is computed.
module wav_header_parser
    import wavhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_of_file,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [2:0]  error_code,
    output logic [7:0]  payload_byte,
    output logic        last_payload,
    output logic [15:0] channel_count,
    output logic [31:0] sample_rate,
    output logic [15:0] sample_bits,
    output logic [31:0] payload_length,
    output logic [31:0] frame_count
);

    logic     result_valid_reg;
    result_t  result_reg;
    result_t  res;
    logic     res_load;
    logic     busy;
    logic     out_free;
    logic     accept;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Handshake on the byte side.
    assign out_free   = !result_valid_reg || !result_stall;
    assign byte_stall = busy || !out_free;
    assign accept     = byte_valid && !byte_stall;

    wavhp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .out_free      (out_free),
        .data_byte     (data_byte),
        .first_of_file (first_of_file),
        .div_rsp       (div_rsp),
        .div_req       (div_req),
        .res           (res),
        .res_load      (res_load),
        .busy          (busy)
    );

    wavhp_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            result_reg <= res;
        end
    end

    assign result_valid   = result_valid_reg;
    assign status         = result_reg.status;
    assign error_code     = result_reg.error_code;
    assign payload_byte   = result_reg.payload_byte;
    assign last_payload   = result_reg.last_payload;
    assign channel_count  = result_reg.channel_count;
    assign sample_rate    = result_reg.sample_rate;
    assign sample_bits    = result_reg.sample_bits;
    assign payload_length = result_reg.payload_length;
    assign frame_count    = result_reg.frame_count;

endmodule

// File: hw/rtl/wavhp_checker.sv
// Port-level checks for the WAV header parser, bound to the top level.
// Depends on wavhp_pkg and wav_header_parser.
module wavhp_checker
    import wavhp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic [7:0]  data_byte,
    input logic        first_of_file,
    input logic        result_valid,
    input logic        result_stall,
    input logic [2:0]  status,
    input logic [2:0]  error_code,
    input logic [7:0]  payload_byte,
    input logic        last_payload,
    input logic [15:0] channel_count,
    input logic [31:0] sample_rate,
    input logic [15:0] sample_bits,
    input logic [31:0] payload_length,
    input logic [31:0] frame_count
);

    logic byte_accept;

    assign byte_accept = byte_valid && !byte_stall;

    // A stalled result transaction keeps its valid and its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status) &&
        $stable(error_code) && $stable(payload_byte) && $stable(frame_count))
        else $error("stalled result changed");

    // A file that does not open with 'R' fails at once with the RIFF error.
    a_no_riff: assert property (@(posedge clk) disable iff (!rst_n)
        byte_accept && first_of_file && (data_byte != MARK_RIFF[7:0]) |=>
        result_valid && (status == ST_ERROR) && (error_code == ERR_NO_RIFF))
        else $error("missing RIFF error on first byte");

    // A file that opens with 'R' gives a plain header result next cycle.
    a_riff_start: assert property (@(posedge clk) disable iff (!rst_n)
        byte_accept && first_of_file && (data_byte == MARK_RIFF[7:0]) |=>
        result_valid && (status == ST_HEADER) && (error_code == ERR_NONE))
        else $error("first byte of a file not reported as header byte");

    // The last-payload mark only comes with a payload result.
    a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_payload |-> (status == ST_PAYLOAD) &&
        (payload_length != 32'd0))
        else $error("last payload mark outside payload");

endmodule

bind wav_header_parser wavhp_checker u_checker (.*);
